### rtl/wildcard_byte_signature_matcher_core_macros.svh
// ----------------------------------------------------------------------------
// wbsm assertion macros
// shared property wrappers for the matcher checker
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_SIGNATURE_MATCHER_CORE_MACROS_SVH
`define WILDCARD_BYTE_SIGNATURE_MATCHER_CORE_MACROS_SVH

// same-cycle implication, reset masked
`define WBSM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wbsm assertion failed");

// next-cycle implication, reset masked
`define WBSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wbsm assertion failed");

`endif

### rtl/wbsm_pkg.sv
// ----------------------------------------------------------------------------
// wbsm_pkg
// shared types, constants and helpers of the wildcard byte signature matcher
// ----------------------------------------------------------------------------
`default_nettype none

package wbsm_pkg;

  localparam int MaxPattern = 64;
  localparam int LenW       = $clog2(MaxPattern + 1);
  localparam int QDepth     = 2;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int QCntW      = $clog2(QDepth + 1);

  localparam logic [7:0] CharSpace    = 8'h20;
  localparam logic [7:0] CharQuestion = 8'h3F;
  localparam logic [7:0] CharZero     = 8'h30;
  localparam logic [7:0] CharNine     = 8'h39;
  localparam logic [7:0] CharUpA      = 8'h41;
  localparam logic [7:0] CharUpF      = 8'h46;
  localparam logic [7:0] CharLowA     = 8'h61;
  localparam logic [7:0] CharLowF     = 8'h66;
  localparam logic [7:0] HexAlphaBase = 8'd10;

  typedef logic [LenW-1:0] len_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_TEXT  = 2'd1,
    OP_RAW   = 2'd2,
    OP_DATA  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_CLEAR,
    CMD_APPEND,
    CMD_DATA
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] value;
    logic       wild;
  } cmd_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [7:0] u;
    logic [4:0] r;
    r = '0;
    u = c;
    if (c >= CharZero && c <= CharNine) begin
      r = {1'b1, 4'(c - CharZero)};
    end else begin
      if (c >= CharLowA && c <= CharLowF) begin
        u = c - CharLowA + CharUpA;
      end
      if (u >= CharUpA && u <= CharUpF) begin
        r = {1'b1, 4'(u - CharUpA + HexAlphaBase)};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/wbsm_fifo.sv
// ----------------------------------------------------------------------------
// wbsm_fifo
// short command queue between the parser front and the match back end
// ----------------------------------------------------------------------------
`default_nettype none

module wbsm_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wbsm_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output wbsm_pkg::cmd_t head_o
);
  import wbsm_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q;
  logic [QPtrW-1:0] rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             push_en;
  logic             pop_en;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign push_en = push_i && !full_o;
  assign pop_en  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_en) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_en) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_en && !pop_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_en && !push_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

### rtl/wbsm_front.sv
// ----------------------------------------------------------------------------
// wbsm_front
// accepts items, runs the signature text parser and emits one command per beat
// ----------------------------------------------------------------------------
`default_nettype none

module wbsm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     opcode_i,
  input  logic [7:0]     character_i,
  input  logic [7:0]     byte_value_i,
  input  logic           q_full_i,
  output logic           cmd_valid_o,
  output wbsm_pkg::cmd_t cmd_o
);
  import wbsm_pkg::*;

  logic [7:0] pend_q, pend_d;
  logic       pend_valid_q, pend_valid_d;
  logic       skip_q, skip_d;
  logic       accept;
  logic       done;
  logic [4:0] hex_hi;
  logic [4:0] hex_lo;
  cmd_t       cmd;

  assign in_ready_o  = !q_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = accept;
  assign cmd_o       = cmd;
  assign hex_hi      = hex_digit(pend_q);
  assign hex_lo      = hex_digit(character_i);

  always_comb begin
    cmd.kind     = CMD_NOP;
    cmd.value    = byte_value_i;
    cmd.wild     = 1'b0;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    skip_d       = skip_q;
    done         = 1'b0;
    case (opcode_e'(opcode_i))
      OP_CLEAR: begin
        cmd.kind     = CMD_CLEAR;
        pend_d       = '0;
        pend_valid_d = 1'b0;
        skip_d       = 1'b0;
      end
      OP_TEXT: begin
        // a '?' right after a '?' is part of the same wildcard
        if (skip_q) begin
          skip_d = 1'b0;
          if (character_i == CharQuestion) begin
            done = 1'b1;
          end
        end
        if (!done && pend_valid_q) begin
          pend_valid_d = 1'b0;
          pend_d       = '0;
          if (hex_hi[4] && hex_lo[4]) begin
            cmd.kind  = CMD_APPEND;
            cmd.value = {hex_hi[3:0], hex_lo[3:0]};
            done      = 1'b1;
          end
        end
        // bad pair: first char dropped, this one parsed fresh
        if (!done) begin
          if (character_i == CharQuestion) begin
            cmd.kind  = CMD_APPEND;
            cmd.value = '0;
            cmd.wild  = 1'b1;
            skip_d    = 1'b1;
          end else if (character_i != CharSpace) begin
            pend_d       = character_i;
            pend_valid_d = 1'b1;
          end
        end
      end
      OP_RAW: begin
        cmd.kind = CMD_APPEND;
        if (character_i == CharQuestion) begin
          cmd.value = '0;
          cmd.wild  = 1'b1;
        end
      end
      OP_DATA: begin
        cmd.kind = CMD_DATA;
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      skip_q       <= 1'b0;
    end else if (accept) begin
      pend_q       <= pend_d;
      pend_valid_q <= pend_valid_d;
      skip_q       <= skip_d;
    end
  end

endmodule

`default_nettype wire

### rtl/wbsm_back.sv
// ----------------------------------------------------------------------------
// wbsm_back
// pattern store, data window and two-stage masked compare with output register
// ----------------------------------------------------------------------------
`default_nettype none

module wbsm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  wbsm_pkg::cmd_t cmd_i,
  output logic           cmd_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           match_o,
  output logic [6:0]     pattern_length_o,
  output logic           overflow_o
);
  import wbsm_pkg::*;

  // pattern kept newest-first so entry k lines up with window entry k
  logic [7:0]      pbyte_q [MaxPattern];
  logic            pwild_q [MaxPattern];
  logic [7:0]      win_q   [MaxPattern];
  logic [7:0]      win_new [MaxPattern];
  len_t            len_q, len_d;
  len_t            seen_q, seen_d;
  logic            ovf_q, ovf_d;
  logic            take;
  logic            do_append;
  logic            do_data;
  logic [MaxPattern-1:0] hits;

  logic                  s1_valid_q;
  logic                  s1_data_q;
  logic                  s1_short_q;
  logic [MaxPattern-1:0] s1_hits_q;
  len_t                  s1_len_q;
  logic                  s1_ovf_q;
  logic                  s1_adv;

  logic                  out_valid_q;
  logic                  match_q;
  len_t                  out_len_q;
  logic                  out_ovf_q;

  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign cmd_ready_o = !s1_valid_q || s1_adv;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign do_append   = take && (cmd_i.kind == CMD_APPEND) && (len_q != len_t'(MaxPattern));
  assign do_data     = take && (cmd_i.kind == CMD_DATA);

  always_comb begin
    len_d  = len_q;
    ovf_d  = ovf_q;
    seen_d = seen_q;
    case (cmd_i.kind)
      CMD_CLEAR: begin
        len_d = '0;
        ovf_d = 1'b0;
      end
      CMD_APPEND: begin
        if (len_q == len_t'(MaxPattern)) begin
          ovf_d = 1'b1;
        end else begin
          len_d = len_q + 1'b1;
        end
      end
      CMD_DATA: begin
        if (seen_q != len_t'(MaxPattern)) begin
          seen_d = seen_q + 1'b1;
        end
      end
      default: begin
        len_d = len_q;
      end
    endcase
  end

  always_comb begin
    win_new[0] = cmd_i.value;
    for (int k = 1; k < MaxPattern; k++) begin
      win_new[k] = win_q[k-1];
    end
    // entries past the pattern length never block a match
    for (int k = 0; k < MaxPattern; k++) begin
      hits[k] = (len_t'(k) >= len_q) || pwild_q[k] || (pbyte_q[k] == win_new[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      seen_q      <= '0;
      ovf_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        len_q  <= len_d;
        seen_q <= seen_d;
        ovf_q  <= ovf_d;
      end
      if (take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_append) begin
      pbyte_q[0] <= cmd_i.value;
      pwild_q[0] <= cmd_i.wild;
      for (int k = 1; k < MaxPattern; k++) begin
        pbyte_q[k] <= pbyte_q[k-1];
        pwild_q[k] <= pwild_q[k-1];
      end
    end
    if (do_data) begin
      win_q <= win_new;
    end
    if (take) begin
      s1_data_q  <= (cmd_i.kind == CMD_DATA);
      s1_short_q <= (seen_d < len_q);
      s1_hits_q  <= hits;
      s1_len_q   <= len_d;
      s1_ovf_q   <= ovf_d;
    end
    if (s1_adv) begin
      match_q   <= s1_data_q && !s1_short_q && (&s1_hits_q);
      out_len_q <= s1_len_q;
      out_ovf_q <= s1_ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign match_o          = match_q;
  assign pattern_length_o = 7'(out_len_q);
  assign overflow_o       = out_ovf_q;

endmodule

`default_nettype wire

### rtl/wildcard_byte_signature_matcher_core.sv
// after its item is accepted, a result passes the command queue, compare register and output register
// throughput: one item and one data-byte window compare per cycle while out_ready_i stays high
// the input stalls only when the 2-entry command queue is full
// reset (async, active low): parser state, pattern length, byte count, overflow
// and all valid flags clear at once; pattern and window storage are not cleared
// ----------------------------------------------------------------------------
// wildcard_byte_signature_matcher_core
// masked byte pattern matcher with wildcard signature parsing
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_signature_matcher_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] character_i,
  input  logic [7:0] byte_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       match_o,
  output logic [6:0] pattern_length_o,
  output logic       overflow_o
);
  import wbsm_pkg::*;

  cmd_t front_cmd;
  logic front_valid;
  logic q_full;
  cmd_t q_head;
  logic q_valid;
  logic back_ready;

  wbsm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .character_i  (character_i),
    .byte_value_i (byte_value_i),
    .q_full_i     (q_full),
    .cmd_valid_o  (front_valid),
    .cmd_o        (front_cmd)
  );

  wbsm_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (front_valid),
    .push_cmd_i (front_cmd),
    .full_o     (q_full),
    .pop_i      (back_ready),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  wbsm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (q_valid),
    .cmd_i            (q_head),
    .cmd_ready_o      (back_ready),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .match_o          (match_o),
    .pattern_length_o (pattern_length_o),
    .overflow_o       (overflow_o)
  );

endmodule

`default_nettype wire

### rtl/wbsm_checker.sv
// ----------------------------------------------------------------------------
// wbsm_checker
// port-level checks on the matcher result stream, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "wildcard_byte_signature_matcher_core_macros.svh"

module wbsm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       match_o,
  input logic [6:0] pattern_length_o,
  input logic       overflow_o
);
  import wbsm_pkg::*;

  logic       out_beat;
  logic       out_stall;
  logic       new_rsp;
  logic [8:0] out_word;
  logic       beat_q;
  logic [6:0] len_q;

  assign out_beat  = out_valid_o && out_ready_i;
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_word  = {match_o, pattern_length_o, overflow_o};
  // valid right after a beat means the next item's result
  assign new_rsp   = beat_q && out_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= 1'b0;
      len_q  <= '0;
    end else begin
      beat_q <= out_beat;
      len_q  <= pattern_length_o;
    end
  end

  // stalled result holds
  `WBSM_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_word))

  // a dropped append means the pattern is full
  `WBSM_ASSERT_IMPL(a_ovf_full, out_valid_o && overflow_o, pattern_length_o == 7'(MaxPattern))

  // length only grows, except back to empty on clear
  `WBSM_ASSERT_IMPL(a_len_mono, new_rsp, pattern_length_o >= len_q || pattern_length_o == '0)

  // at most one entry per beat
  `WBSM_ASSERT_IMPL(a_len_step, new_rsp && pattern_length_o != '0, pattern_length_o <= len_q + 7'd1)

endmodule

bind wildcard_byte_signature_matcher_core wbsm_checker u_wbsm_checker (.*);

`default_nettype wire

### dv/wildcard_byte_signature_matcher_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_signature_matcher_core_tb
// drives signature text, raw pattern and data beats into the matcher under
// random stalls on both sides, predicts every result beat and compares it
// field by field in order of arrival
// ----------------------------------------------------------------------------

module wildcard_byte_signature_matcher_core_tb;
  import wbsm_pkg::*;

  localparam int  NumRandom  = 1450;
  localparam int  TailCycles = 20;
  localparam int  IdlePct    = 31;
  localparam int  CalmLo     = 600;
  localparam int  CalmHi     = 900;
  localparam longint LimitNs = 2_000_000;

  typedef struct packed {
    opcode_e    op;
    logic [7:0] ch;
    logic [7:0] bv;
  } beat_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] len;
    logic       ovf;
  } scan_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] opcode = OP_CLEAR;
  logic [7:0] character = 8'h00;
  logic [7:0] byte_value = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       match;
  logic [6:0] pattern_length;
  logic       overflow;

  beat_t        pending_beats[$];
  scan_result_t expected_results[$];
  int           mismatches = 0;
  int           beats_in = 0;
  int           results_in = 0;
  int           hits_seen = 0;
  int           ovf_seen = 0;

  // predicted matcher state
  logic [7:0] pat_byte [MaxPattern];
  bit         pat_wild [MaxPattern];
  int         pat_len = 0;
  logic [7:0] win [MaxPattern] = '{default: 8'h00};
  int         seen = 0;
  logic [7:0] pend_ch = 8'h00;
  bit         pend_v = 1'b0;
  bit         skip_q = 1'b0;
  bit         ovf = 1'b0;

  wildcard_byte_signature_matcher_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (opcode),
    .character_i     (character),
    .byte_value_i    (byte_value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .match_o         (match),
    .pattern_length_o(pattern_length),
    .overflow_o      (overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int nibble_of(logic [7:0] c);
    if (c >= CharZero && c <= CharNine) return int'(c - CharZero);
    if (c >= CharLowA && c <= CharLowF) return int'(c - CharLowA) + 10;
    if (c >= CharUpA && c <= CharUpF) return int'(c - CharUpA) + 10;
    return -1;
  endfunction

  function automatic void add_entry(logic [7:0] v, bit wc);
    if (pat_len >= MaxPattern) begin
      ovf = 1'b1;
      return;
    end
    pat_byte[pat_len] = v;
    pat_wild[pat_len] = wc;
    pat_len++;
  endfunction

  function automatic void parse_text(logic [7:0] c);
    int hi, lo;
    if (skip_q) begin
      skip_q = 1'b0;
      if (c == CharQuestion) return;
    end
    if (pend_v) begin
      hi = nibble_of(pend_ch);
      lo = nibble_of(c);
      pend_v = 1'b0;
      pend_ch = 8'h00;
      if (hi >= 0 && lo >= 0) begin
        add_entry(8'(hi * 16 + lo), 1'b0);
        return;
      end
    end
    // a broken pair falls through so the new char is parsed fresh
    if (c == CharSpace) return;
    if (c == CharQuestion) begin
      add_entry(8'h00, 1'b1);
      skip_q = 1'b1;
      return;
    end
    pend_ch = c;
    pend_v = 1'b1;
  endfunction

  function automatic bit shift_data(logic [7:0] v);
    for (int i = MaxPattern - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = v;
    if (seen < MaxPattern) seen++;
    if (pat_len == 0) return 1'b1;
    if (seen < pat_len) return 1'b0;
    // last pattern entry lines up with the newest byte
    for (int i = 0; i < pat_len; i++) begin
      if (!pat_wild[i] && pat_byte[i] != win[pat_len-1-i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic scan_result_t predict_scan(beat_t b);
    scan_result_t r;
    r.hit = 1'b0;
    case (b.op)
      OP_CLEAR: begin
        pat_len = 0;
        pend_ch = 8'h00;
        pend_v = 1'b0;
        skip_q = 1'b0;
        ovf = 1'b0;
      end
      OP_TEXT: parse_text(b.ch);
      OP_RAW:  add_entry(b.bv, b.ch == CharQuestion);
      default: r.hit = shift_data(b.bv);
    endcase
    r.len = 7'(pat_len);
    r.ovf = ovf;
    return r;
  endfunction

  function automatic void queue_beat(opcode_e op, logic [7:0] ch, logic [7:0] bv);
    beat_t b;
    b.op = op;
    b.ch = ch;
    b.bv = bv;
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return CharZero + 8'(n);
    return ($urandom_range(1) ? CharUpA : CharLowA) + 8'(n) - HexAlphaBase;
  endfunction

  task automatic build_directed();
    queue_beat(OP_DATA, 8'h00, 8'h00);     // empty pattern matches anything
    queue_beat(OP_TEXT, CharSpace, 8'hFF);
    queue_beat(OP_TEXT, "4", 8'h00);
    queue_beat(OP_TEXT, "d", 8'h00);
    queue_beat(OP_TEXT, CharQuestion, 8'h00);
    queue_beat(OP_TEXT, CharQuestion, 8'h00); // swallowed second '?'
    queue_beat(OP_RAW, 8'hFF, 8'hFF);
    queue_beat(OP_DATA, 8'hFF, 8'h4D);     // window still shorter than pattern
    queue_beat(OP_DATA, 8'h00, 8'h12);
    queue_beat(OP_DATA, 8'h00, 8'hFF);
    queue_beat(OP_TEXT, "G", 8'h00);       // bad pair, second char reparsed
    queue_beat(OP_TEXT, "e", 8'h00);
    queue_beat(OP_TEXT, "F", 8'h00);
    queue_beat(OP_RAW, CharQuestion, 8'h5A);
    queue_beat(OP_TEXT, "Z", 8'h00);
    queue_beat(OP_TEXT, CharSpace, 8'h00);
    queue_beat(OP_CLEAR, 8'hFF, 8'hFF);
    queue_beat(OP_RAW, 8'h00, 8'h00);
    queue_beat(OP_RAW, 8'h3E, 8'hFF);
    queue_beat(OP_DATA, 8'h00, 8'h00);
    queue_beat(OP_DATA, 8'h00, 8'hFF);
    queue_beat(OP_TEXT, CharQuestion, 8'h00);
    queue_beat(OP_CLEAR, 8'h00, 8'h00);    // clear drops the armed '?' skip
    queue_beat(OP_TEXT, "A", 8'h00);
    queue_beat(OP_TEXT, CharQuestion, 8'h00);
    queue_beat(OP_TEXT, CharQuestion, 8'h00);
  endtask

  task automatic build_scan_sequences();
    logic [7:0] pat_val[$];
    bit         pat_wc[$];
    logic [7:0] m;
    int         n_len, k, mode, mark, made;
    made = 0;
    while (made < NumRandom) begin
      mark = pending_beats.size();
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(5, 1)) begin
          queue_beat(opcode_e'($urandom_range(3)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        end
      end else begin
        if ($urandom_range(9) != 0) queue_beat(OP_CLEAR, 8'($urandom), 8'($urandom));
        k = $urandom_range(99);
        n_len = (k < 84) ? $urandom_range(8, 1) :
                (k < 94) ? $urandom_range(40, 9) : $urandom_range(70, 60);
        pat_val.delete();
        pat_wc.delete();
        for (int i = 0; i < n_len; i++) begin
          pat_val.insert(pat_val.size(), 8'($urandom_range(255)));
          pat_wc.insert(pat_wc.size(), $urandom_range(4) == 0);
        end
        mode = $urandom_range(2);
        for (int i = 0; i < n_len; i++) begin
          if (mode == 1 || (mode == 2 && $urandom_range(1))) begin
            do m = 8'($urandom_range(255)); while (m == CharQuestion);
            if (pat_wc[i]) queue_beat(OP_RAW, CharQuestion, 8'($urandom_range(255)));
            else queue_beat(OP_RAW, m, pat_val[i]);
          end else if (pat_wc[i]) begin
            // "??" or "? " keeps a following wildcard from being swallowed
            queue_beat(OP_TEXT, CharQuestion, 8'($urandom));
            queue_beat(OP_TEXT, $urandom_range(1) ? CharQuestion : CharSpace, 8'($urandom));
          end else begin
            queue_beat(OP_TEXT, hex_char(pat_val[i][7:4]), 8'($urandom));
            queue_beat(OP_TEXT, hex_char(pat_val[i][3:0]), 8'($urandom));
            if ($urandom_range(3) == 0) queue_beat(OP_TEXT, CharSpace, 8'($urandom));
          end
          if ($urandom_range(49) == 0)
            queue_beat(OP_TEXT, 8'($urandom_range(255)), 8'($urandom));
        end
        if (n_len > MaxPattern) n_len = MaxPattern;
        repeat ($urandom_range(2, 1)) begin
          repeat ($urandom_range(6)) queue_beat(OP_DATA, 8'($urandom), 8'($urandom_range(255)));
          for (int i = 0; i < n_len; i++) begin
            queue_beat(OP_DATA, 8'($urandom),
                       (pat_wc[i] || $urandom_range(29) == 0) ? 8'($urandom_range(255))
                                                              : pat_val[i]);
          end
        end
      end
      made += pending_beats.size() - mark;
    end
  endtask

  // driver: predicts on acceptance, then offers the next beat
  always @(posedge clk) begin : drive_proc
    beat_t        b;
    scan_result_t r;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        b.op = opcode_e'(opcode);
        b.ch = character;
        b.bv = byte_value;
        r = predict_scan(b);
        expected_results.insert(expected_results.size(), r);
        beats_in++;
        if (r.hit) hits_seen++;
        if (r.ovf) ovf_seen++;
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 &&
            ((beats_in >= CalmLo && beats_in < CalmHi) || $urandom_range(99) >= IdlePct)) begin
          b = pending_beats.pop_front();
          in_valid <= 1'b1;
          opcode <= b.op;
          character <= b.ch;
          byte_value <= b.bv;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat against the oldest prediction
  always @(posedge clk) begin : check_proc
    scan_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_in++;
        if (expected_results.size() == 0) begin
          flag_mismatch("result beat with nothing outstanding");
        end else begin
          want = expected_results.pop_front();
          if (match !== want.hit)
            flag_mismatch($sformatf("match got %0b expected %0b", match, want.hit));
          if (pattern_length !== want.len)
            flag_mismatch($sformatf("pattern_length got %0d expected %0d",
                                    pattern_length, want.len));
          if (overflow !== want.ovf)
            flag_mismatch($sformatf("overflow got %0b expected %0b", overflow, want.ovf));
        end
      end
      out_ready <= (results_in >= CalmLo && results_in < CalmHi) ||
                   $urandom_range(99) >= IdlePct;
    end
  end

  initial begin
    build_directed();
    build_scan_sequences();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (TailCycles) @(negedge clk);
    if (expected_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("covered %0d beats in and %0d results out, %0d window hits",
             beats_in, results_in, hits_seen);
    $display("%0d results carried the sticky overflow flag", ovf_seen);
    if (mismatches == 0) begin
      $display("wildcard_byte_signature_matcher_core regression: pass");
    end else begin
      $display("wildcard_byte_signature_matcher_core regression: fail");
    end
    $finish;
  end

  initial begin
    #(LimitNs);
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("wildcard_byte_signature_matcher_core regression: fail");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/wbsm_pkg.sv
rtl/wbsm_fifo.sv
rtl/wbsm_front.sv
rtl/wbsm_back.sv
rtl/wildcard_byte_signature_matcher_core.sv
rtl/wbsm_checker.sv
dv/wildcard_byte_signature_matcher_core_tb.sv
